// ----- rtl/core/mch_pkg.sv -----
// mch_pkg: shared widths, function codes, sequencer states and the arctangent table
// for the calibrated compass heading block; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mch_pkg;

  localparam int FUNC_W = 2;
  localparam int MAG_W  = 16;
  localparam int CORR_W = 18;
  localparam int HEAD_W = 12;

  localparam logic [FUNC_W-1:0] FUNC_MEASURE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CAL     = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FINISH  = 2'd2;

  // scale is unsigned fixed point with this many fraction bits
  localparam int SCALE_FRAC_BITS = 14;
  localparam logic [MAG_W-1:0] SCALE_ONE = MAG_W'(1 << SCALE_FRAC_BITS);

  // dividend of the scale division: ((dx + dy) << F) + d
  localparam int NUM_W     = MAG_W + 2 + SCALE_FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(NUM_W);

  localparam int CORDIC_STEPS = 16;
  localparam int MAX_STEPS    = 24;
  localparam int STEP_W       = $clog2(MAX_STEPS);
  localparam int ATAN_W       = 25;
  localparam int CW           = 21;  // cordic x/y width, covers gain and sign flip
  localparam int ZW           = 31;  // angle accumulator, 1/65536 of a tenth

  localparam int HALF_TURN_UNITS = 1800 * 65536;
  localparam int FULL_TURN_UNITS = 3600 * 65536;
  localparam int HALF_TENTH      = 32768;
  localparam int TENTHS_TURN     = 3600;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPD,
    ST_DIV,
    ST_MUL_X,
    ST_MUL_Y,
    ST_SAT_Y,
    ST_PRE,
    ST_ROT,
    ST_HEAD
  } mch_state_t;

  // atan(2^-i) in 1/65536 of a tenth of a degree
  function automatic logic [ATAN_W-1:0] atan_units(input logic [STEP_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 25'd29491200;
      5'd1:    v = 25'd17409672;
      5'd2:    v = 25'd9198793;
      5'd3:    v = 25'd4669451;
      5'd4:    v = 25'd2343786;
      5'd5:    v = 25'd1173036;
      5'd6:    v = 25'd586661;
      5'd7:    v = 25'd293348;
      5'd8:    v = 25'd146676;
      5'd9:    v = 25'd73339;
      5'd10:   v = 25'd36669;
      5'd11:   v = 25'd18335;
      5'd12:   v = 25'd9167;
      5'd13:   v = 25'd4584;
      5'd14:   v = 25'd2292;
      5'd15:   v = 25'd1146;
      5'd16:   v = 25'd573;
      5'd17:   v = 25'd286;
      5'd18:   v = 25'd143;
      5'd19:   v = 25'd72;
      5'd20:   v = 25'd36;
      5'd21:   v = 25'd18;
      5'd22:   v = 25'd9;
      5'd23:   v = 25'd4;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/magnetometer_calibrated_heading.sv -----
// magnetometer_calibrated_heading: hard/soft iron correction and cordic heading
// depends on mch_pkg
`timescale 1ns / 1ps
`default_nettype none

// Usage
// Input channel (in_valid/in_ready) carries one magnetometer X/Y sample and a
// function code: measure, calibration sample (widens the min/max envelope) or
// finish (sets offsets to the envelope midpoints and, when both axes have
// positive extent, recomputes the scales). Each request yields exactly one
// result on the output channel (out_valid/out_ready): corrected X/Y and the
// heading in tenths of a degree, 0..3599.
// Timing: one request at a time. A measure or calibration request passes through
// the update, multiply, saturate, pre-rotation, cordic and heading states before
// out_valid, paced by the one-step-per-cycle cordic loop and the shared multiplier
// used once per axis. A finish request that rewrites the scales also runs the
// bit-serial restoring divider, one axis after the other. in_ready is high only
// while the sequencer is idle.
// The result sits in an output register; the next request is taken while it
// waits, and the sequencer holds in its last step if the receiver still stalls.
// Reset: envelope to empty (min at most positive, max at most negative),
// offsets to zero, scales to one, no result pending.
module magnetometer_calibrated_heading (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire        [mch_pkg::FUNC_W-1:0]      in_func,
  input  wire signed [mch_pkg::MAG_W-1:0]       in_mag_x,
  input  wire signed [mch_pkg::MAG_W-1:0]       in_mag_y,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic       [mch_pkg::HEAD_W-1:0]      out_heading_tenths,
  output logic signed [mch_pkg::CORR_W-1:0]     out_corrected_x,
  output logic signed [mch_pkg::CORR_W-1:0]     out_corrected_y,
  output logic                                  out_scales_updated
);
  import mch_pkg::*;

  localparam int PROD_W = 2 * (MAG_W + 1);
  localparam logic signed [PROD_W:0] RND = (PROD_W + 1)'(1 << (SCALE_FRAC_BITS - 1));
  localparam logic signed [PROD_W:0] CORR_MAX = (PROD_W + 1)'((1 << (CORR_W - 1)) - 1);
  localparam logic signed [PROD_W:0] CORR_MIN = -(PROD_W + 1)'(1 << (CORR_W - 1));

  mch_state_t state_r, state_nxt;

  logic [FUNC_W-1:0]        func_r;
  logic signed [MAG_W-1:0]  mx_r, my_r;
  logic signed [MAG_W-1:0]  min_x_r, max_x_r, min_y_r, max_y_r;
  logic signed [MAG_W-1:0]  offset_x_r, offset_y_r;
  logic [MAG_W-1:0]         scale_x_r, scale_y_r;
  logic                     updated_r;

  logic                     div_axis_r;
  logic [DIV_CNT_W-1:0]     div_cnt_r;
  logic [MAG_W:0]           rem_r;
  logic [NUM_W-1:0]         quo_r;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [CORR_W-1:0] cx_r, cy_r;
  logic                     zero_vec_r;
  logic signed [CW-1:0]     x_r, y_r;
  logic signed [ZW-1:0]     z_r;
  logic [STEP_W-1:0]        step_r;

  logic                     out_valid_r;
  logic [HEAD_W-1:0]        out_head_r;
  logic signed [CORR_W-1:0] out_cx_r, out_cy_r;
  logic                     out_upd_r;

  // envelope and calibration terms
  logic signed [MAG_W:0] dx, dy, osum_x, osum_y;
  logic                  dx_pos, dy_pos, cal_go;
  logic [MAG_W:0]        dsum;
  logic [NUM_W-1:0]      num_x, num_y;
  logic [MAG_W-1:0]      d_self;
  logic [MAG_W:0]        divisor;
  logic [MAG_W+1:0]      rem_sh, rem_dif;
  logic                  sub_ok;
  logic [MAG_W:0]        rem_nxt;
  logic [NUM_W-1:0]      quo_step;
  logic [MAG_W-1:0]      q_sat;
  logic                  div_last;

  // correction multiplier, shared by both axes
  logic signed [MAG_W:0]    diff_x, diff_y, mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [CORR_W-1:0] prod_sat;

  // cordic step
  logic signed [CW-1:0] cxe, cye, xs, ys;
  logic signed [ZW-1:0] at;
  logic                 rot_last;

  // heading wrap
  logic signed [ZW-1:0] tsum;
  logic [12:0]          hd, hd_wrap;
  logic [HEAD_W-1:0]    heading;

  logic out_free, out_load;

  function automatic logic signed [CORR_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W:0] r;
    logic signed [PROD_W:0] s;
    r = $signed({p[PROD_W-1], p}) + RND;
    s = r >>> SCALE_FRAC_BITS;
    if (s > CORR_MAX) begin
      return CORR_MAX[CORR_W-1:0];
    end else if (s < CORR_MIN) begin
      return CORR_MIN[CORR_W-1:0];
    end
    return s[CORR_W-1:0];
  endfunction

  always_comb begin
    dx = $signed({max_x_r[MAG_W-1], max_x_r}) - $signed({min_x_r[MAG_W-1], min_x_r});
    dy = $signed({max_y_r[MAG_W-1], max_y_r}) - $signed({min_y_r[MAG_W-1], min_y_r});
    dx_pos = !dx[MAG_W] && (dx[MAG_W-1:0] != '0);
    dy_pos = !dy[MAG_W] && (dy[MAG_W-1:0] != '0);
    cal_go = (func_r == FUNC_FINISH) && dx_pos && dy_pos;
    osum_x = $signed({min_x_r[MAG_W-1], min_x_r}) + $signed({max_x_r[MAG_W-1], max_x_r});
    osum_y = $signed({min_y_r[MAG_W-1], min_y_r}) + $signed({max_y_r[MAG_W-1], max_y_r});
    dsum = {1'b0, dx[MAG_W-1:0]} + {1'b0, dy[MAG_W-1:0]};
    num_x = (NUM_W'(dsum) << SCALE_FRAC_BITS) + NUM_W'(dx[MAG_W-1:0]);
    num_y = (NUM_W'(dsum) << SCALE_FRAC_BITS) + NUM_W'(dy[MAG_W-1:0]);
    d_self = div_axis_r ? dy[MAG_W-1:0] : dx[MAG_W-1:0];
    divisor = {d_self, 1'b0};
    rem_sh = {rem_r, quo_r[NUM_W-1]};
    sub_ok = rem_sh >= {1'b0, divisor};
    rem_dif = rem_sh - {1'b0, divisor};
    rem_nxt = sub_ok ? rem_dif[MAG_W:0] : rem_sh[MAG_W:0];
    quo_step = {quo_r[NUM_W-2:0], sub_ok};
    q_sat = (|quo_step[NUM_W-1:MAG_W]) ? '1 : quo_step[MAG_W-1:0];
    div_last = (div_cnt_r == '0);
  end

  always_comb begin
    diff_x = $signed({mx_r[MAG_W-1], mx_r}) - $signed({offset_x_r[MAG_W-1], offset_x_r});
    diff_y = $signed({my_r[MAG_W-1], my_r}) - $signed({offset_y_r[MAG_W-1], offset_y_r});
    mul_a = (state_r == ST_MUL_X) ? diff_x : diff_y;
    mul_b = (state_r == ST_MUL_X) ? $signed({1'b0, scale_x_r}) : $signed({1'b0, scale_y_r});
    mul_p = mul_a * mul_b;
    prod_sat = round_sat(prod_r);
  end

  always_comb begin
    cxe = {{(CW - CORR_W){cx_r[CORR_W-1]}}, cx_r};
    cye = {{(CW - CORR_W){cy_r[CORR_W-1]}}, cy_r};
    xs = x_r >>> step_r;
    ys = y_r >>> step_r;
    at = $signed(ZW'(atan_units(step_r)));
    rot_last = (step_r == STEP_W'(CORDIC_STEPS - 1));
    tsum = z_r + $signed(ZW'(FULL_TURN_UNITS + HALF_TENTH));
    hd = tsum[16 +: 13];
    hd_wrap = (hd >= 13'(TENTHS_TURN)) ? hd - 13'(TENTHS_TURN) : hd;
    heading = zero_vec_r ? '0 : hd_wrap[HEAD_W-1:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_UPD;
      ST_UPD:   state_nxt = cal_go ? ST_DIV : ST_MUL_X;
      ST_DIV:   if (div_last && div_axis_r) state_nxt = ST_MUL_X;
      ST_MUL_X: state_nxt = ST_MUL_Y;
      ST_MUL_Y: state_nxt = ST_SAT_Y;
      ST_SAT_Y: state_nxt = ST_PRE;
      ST_PRE:   state_nxt = ST_ROT;
      ST_ROT:   if (rot_last) state_nxt = ST_HEAD;
      ST_HEAD:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    out_free = !out_valid_r || out_ready;
    in_ready = (state_r == ST_IDLE);
    out_load = (state_r == ST_HEAD) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      min_x_r     <= {1'b0, {(MAG_W - 1){1'b1}}};
      min_y_r     <= {1'b0, {(MAG_W - 1){1'b1}}};
      max_x_r     <= {1'b1, {(MAG_W - 1){1'b0}}};
      max_y_r     <= {1'b1, {(MAG_W - 1){1'b0}}};
      offset_x_r  <= '0;
      offset_y_r  <= '0;
      scale_x_r   <= SCALE_ONE;
      scale_y_r   <= SCALE_ONE;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_UPD) begin
        case (func_r)
          FUNC_CAL: begin
            if (mx_r < min_x_r) min_x_r <= mx_r;
            if (mx_r > max_x_r) max_x_r <= mx_r;
            if (my_r < min_y_r) min_y_r <= my_r;
            if (my_r > max_y_r) max_y_r <= my_r;
          end
          FUNC_FINISH: begin
            offset_x_r <= osum_x[MAG_W:1];
            offset_y_r <= osum_y[MAG_W:1];
          end
          default: begin
          end
        endcase
      end
      if (state_r == ST_DIV && div_last) begin
        if (div_axis_r) begin
          scale_y_r <= q_sat;
        end else begin
          scale_x_r <= q_sat;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_r <= in_func;
      mx_r   <= in_mag_x;
      my_r   <= in_mag_y;
    end
    unique case (state_r)
      ST_UPD: begin
        updated_r  <= cal_go;
        div_axis_r <= 1'b0;
        div_cnt_r  <= DIV_CNT_W'(NUM_W - 1);
        rem_r      <= '0;
        quo_r      <= num_x;
      end
      ST_DIV: begin
        if (div_last) begin
          // second axis reuses the same divider
          div_axis_r <= 1'b1;
          div_cnt_r  <= DIV_CNT_W'(NUM_W - 1);
          rem_r      <= '0;
          quo_r      <= num_y;
        end else begin
          div_cnt_r <= div_cnt_r - 1'b1;
          rem_r     <= rem_nxt;
          quo_r     <= quo_step;
        end
      end
      ST_MUL_X: prod_r <= mul_p;
      ST_MUL_Y: begin
        cx_r   <= prod_sat;
        prod_r <= mul_p;
      end
      ST_SAT_Y: cy_r <= prod_sat;
      ST_PRE: begin
        zero_vec_r <= (cx_r == '0) && (cy_r == '0);
        step_r     <= '0;
        // left half plane: flip the vector and start from a half turn
        if (cx_r[CORR_W-1]) begin
          x_r <= -cxe;
          y_r <= -cye;
          z_r <= $signed(ZW'(HALF_TURN_UNITS));
        end else begin
          x_r <= cxe;
          y_r <= cye;
          z_r <= '0;
        end
      end
      ST_ROT: begin
        step_r <= step_r + 1'b1;
        if (!y_r[CW-1]) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + at;
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - at;
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_head_r <= heading;
      out_cx_r   <= cx_r;
      out_cy_r   <= cy_r;
      out_upd_r  <= updated_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_heading_tenths = out_head_r;
  assign out_corrected_x    = out_cx_r;
  assign out_corrected_y    = out_cy_r;
  assign out_scales_updated = out_upd_r;

`ifndef SYNTHESIS
  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_heading_tenths < HEAD_W'(TENTHS_TURN)))
    else $error("heading out of range");

  a_envelope_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD && func_r == FUNC_CAL) |=>
      (min_x_r <= max_x_r && min_y_r <= max_y_r))
    else $error("envelope min above max after calibration sample");

  a_rot_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROT) |-> (step_r < STEP_W'(CORDIC_STEPS)))
    else $error("cordic step count overrun");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (state_r != ST_IDLE || $past(state_r) != ST_HEAD))
    else $error("result loaded over a stalled result");
`endif

endmodule

`default_nettype wire
